### rtl/core/bsw_pkg.sv
package bsw_pkg;

  localparam int MAX_KEYS    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int CAPACITY    = (MAX_KEYS < STORE_DEPTH) ? MAX_KEYS : STORE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 16;
  localparam int SWAP_W      = 11;

  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [SWAP_W-1:0] SWAP_SAT = {SWAP_W{1'b1}};

  // Steps of the control program.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_INIT,
    ST_LOAD_HELD,
    ST_CMP,
    ST_PASS_END,
    ST_OUT_RD,
    ST_OUT
  } step_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_POS1,
    RD_POS2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_MIN,
    WR_HELD
  } wr_sel_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_FINAL,
    CND_SORTED,
    CND_PASS_END,
    CND_OUT_LAST
  } cond_t;

  typedef struct packed {
    logic    busy;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    ld_held;
    logic    cmp;
    logic    pos_clr;
    logic    pos_inc;
    logic    pass_inc;
    logic    emit;
    cond_t   cond;
    step_t   jump_to;
    step_t   next_step;
  } uword_t;

  // Port bundle of the key store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w           = '0;
    w.rd_sel    = RD_ZERO;
    w.wr_sel    = WR_NONE;
    w.cond      = CND_NONE;
    w.jump_to   = ST_IDLE;
    w.next_step = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.wr_sel    = WR_KEY;
        w.cond      = CND_FINAL;
        w.jump_to   = ST_PASS_INIT;
        w.next_step = ST_IDLE;
      end
      ST_PASS_INIT: begin
        w.busy      = 1'b1;
        w.pos_clr   = 1'b1;
        w.cond      = CND_SORTED;
        w.jump_to   = ST_OUT_RD;
        w.next_step = ST_LOAD_HELD;
      end
      ST_LOAD_HELD: begin
        w.busy      = 1'b1;
        w.ld_held   = 1'b1;
        w.rd_sel    = RD_POS1;
        w.next_step = ST_CMP;
      end
      ST_CMP: begin
        w.busy      = 1'b1;
        w.cmp       = 1'b1;
        w.wr_sel    = WR_MIN;
        w.pos_inc   = 1'b1;
        w.rd_sel    = RD_POS2;
        w.cond      = CND_PASS_END;
        w.jump_to   = ST_PASS_END;
        w.next_step = ST_CMP;
      end
      ST_PASS_END: begin
        w.busy      = 1'b1;
        w.wr_sel    = WR_HELD;
        w.pass_inc  = 1'b1;
        w.next_step = ST_PASS_INIT;
      end
      ST_OUT_RD: begin
        w.busy      = 1'b1;
        w.pos_clr   = 1'b1;
        w.next_step = ST_OUT;
      end
      ST_OUT: begin
        w.busy      = 1'b1;
        w.emit      = 1'b1;
        w.pos_inc   = 1'b1;
        w.rd_sel    = RD_POS1;
        w.cond      = CND_OUT_LAST;
        w.jump_to   = ST_IDLE;
        w.next_step = ST_OUT;
      end
      default: begin
        w.next_step = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/bsw_store.sv
module bsw_store (
  input  logic                       clk,
  input  bsw_pkg::store_req_t        req,
  output logic [bsw_pkg::KEY_W-1:0]  rdata
);
  import bsw_pkg::*;

  logic [KEY_W-1:0] mem [STORE_DEPTH];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/bubble_sort_with_swap_count.sv
// Bubble sort with swap count.
//
// Input channel: an item is one key (in_key_in, unsigned hundredths) with
// in_final_key marking the last key of a set. An item is taken at a rising
// edge where start is high and busy is low. While loading, busy stays low,
// so keys stream in at one item per cycle. Keys past the 64-entry store are
// dropped and the run is flagged on out_dropped_keys.
// The final key starts the sort and busy rises on the next cycle. The sort
// is a short control program stepping over one store with a single write
// and a single registered read port. The compare passes run first, then
// a setup step, then one result per cycle.
// Results: each is held on the out_ ports for one cycle with out_strobe
// high; the receiver cannot stall, so no backpressure exists. The last
// result carries out_end_of_run and the swap count on out_swap_total.
// busy falls the cycle the last result is presented, so the next set may
// start loading while that result is on the ports.
// Reset (rst_n low, synchronous) empties the store logically: count, swap
// counter, overflow flag and the program step return to zero and idle.
module bubble_sort_with_swap_count (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bsw_pkg::KEY_W-1:0]   in_key_in,
  input  logic                        in_final_key,
  output logic                        out_strobe,
  output logic [bsw_pkg::KEY_W-1:0]   out_sorted_key,
  output logic [bsw_pkg::SWAP_W-1:0]  out_swap_total,
  output logic                        out_end_of_run,
  output logic                        out_dropped_keys
);
  import bsw_pkg::*;

  step_t             step_r, step_nxt;
  uword_t            uw;
  logic              accept;
  logic              room;
  logic              cond_true;
  logic              run_done;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SWAP_W-1:0] swap_r, swap_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  pass_r, pass_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0]  held_r, held_nxt;

  logic [KEY_W-1:0]  rdata;
  logic              gt;
  store_req_t        req;
  logic [CNT_W:0]    pass_end_sum;
  logic [CNT_W-1:0]  pos_plus1;

  logic              strobe_r;
  logic [KEY_W-1:0]  key_out_r;
  logic [SWAP_W-1:0] swap_out_r;
  logic              eor_r;
  logic              drop_r;

  bsw_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign uw     = ucode(step_r);
  assign busy   = uw.busy;
  assign accept = start && !uw.busy;
  assign room   = (count_r < CAP_CNT);
  assign gt     = (held_r > rdata);

  assign pos_plus1    = {1'b0, pos_r} + CNT_W'(1);
  assign pass_end_sum = {1'b0, pos_plus1} + {1'b0, pass_r};

  // Branch condition selected by the current control word.
  always_comb begin
    unique case (uw.cond)
      CND_NONE:     cond_true = 1'b0;
      CND_FINAL:    cond_true = accept && in_final_key;
      CND_SORTED:   cond_true = (pass_r >= count_r);
      CND_PASS_END: cond_true = (pass_end_sum == {1'b0, count_r});
      CND_OUT_LAST: cond_true = (pos_plus1 == count_r);
      default:      cond_true = 1'b0;
    endcase
  end

  assign run_done = uw.emit && cond_true;
  assign step_nxt = cond_true ? uw.jump_to : uw.next_step;

  // Store port steering.
  always_comb begin
    req.we    = 1'b0;
    req.waddr = pos_r;
    req.wdata = held_r;
    unique case (uw.wr_sel)
      WR_NONE: begin
        req.we = 1'b0;
      end
      WR_KEY: begin
        req.we    = accept && room;
        req.waddr = count_r[ADDR_W-1:0];
        req.wdata = in_key_in;
      end
      WR_MIN: begin
        req.we    = 1'b1;
        req.wdata = gt ? rdata : held_r;
      end
      WR_HELD: begin
        req.we    = 1'b1;
        req.wdata = held_r;
      end
      default: begin
        req.we = 1'b0;
      end
    endcase
    unique case (uw.rd_sel)
      RD_ZERO: req.raddr = '0;
      RD_POS1: req.raddr = pos_r + ADDR_W'(1);
      RD_POS2: req.raddr = pos_r + ADDR_W'(2);
      default: req.raddr = '0;
    endcase
  end

  // Datapath next values.
  always_comb begin
    count_nxt = count_r;
    swap_nxt  = swap_r;
    ovf_nxt   = ovf_r;
    pass_nxt  = pass_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;

    if (uw.wr_sel == WR_KEY && accept) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_final_key) begin
        pass_nxt = CNT_W'(1);
        swap_nxt = '0;
      end
    end

    if (uw.pass_inc) begin
      pass_nxt = pass_r + CNT_W'(1);
    end

    priority if (uw.pos_clr) begin
      pos_nxt = '0;
    end else if (uw.pos_inc) begin
      pos_nxt = pos_r + ADDR_W'(1);
    end else begin
      pos_nxt = pos_r;
    end

    // The larger of the pair rides on to the next position.
    priority if (uw.ld_held) begin
      held_nxt = rdata;
    end else if (uw.cmp) begin
      held_nxt = gt ? held_r : rdata;
    end else begin
      held_nxt = held_r;
    end

    if (uw.cmp && gt && swap_r != SWAP_SAT) begin
      swap_nxt = swap_r + SWAP_W'(1);
    end

    if (run_done) begin
      count_nxt = '0;
      swap_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= ST_IDLE;
      count_r  <= '0;
      swap_r   <= '0;
      ovf_r    <= 1'b0;
      pass_r   <= '0;
      pos_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      count_r  <= count_nxt;
      swap_r   <= swap_nxt;
      ovf_r    <= ovf_nxt;
      pass_r   <= pass_nxt;
      pos_r    <= pos_nxt;
      strobe_r <= uw.emit;
    end
  end

  // Result payload registers; the held key needs no reset.
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (uw.emit) begin
      key_out_r  <= rdata;
      swap_out_r <= run_done ? swap_r : '0;
      eor_r      <= run_done;
      drop_r     <= ovf_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_sorted_key   = key_out_r;
  assign out_swap_total   = swap_out_r;
  assign out_end_of_run   = eor_r;
  assign out_dropped_keys = drop_r;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsw_pkg::*;

  // The run is cut off here if the block stops answering. The limit
  // leaves a wide margin over the slowest set (a full store) and the whole run.
  localparam int LIMIT_CYCLES  = 400000;
  // Cycles to watch for stray results once nothing is expected any more.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 190;
  localparam int DIRECTED_ROWS = 20;

  // One sorted key as it leaves the block.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SWAP_W-1:0] swaps;
    logic              end_of_run;
    logic              dropped;
  } sorted_result_t;

  // One row of the directed table. Where typed is set, the single result
  // of that set is written out by hand. Otherwise the predictor decides.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             final_key;
    logic             typed;
    sorted_result_t   result;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KEY_W-1:0]  in_key_in;
  logic              in_final_key;
  logic              out_strobe;
  logic [KEY_W-1:0]  out_sorted_key;
  logic [SWAP_W-1:0] out_swap_total;
  logic              out_end_of_run;
  logic              out_dropped_keys;

  bubble_sort_with_swap_count DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_key_in        (in_key_in),
    .in_final_key     (in_final_key),
    .out_strobe       (out_strobe),
    .out_sorted_key   (out_sorted_key),
    .out_swap_total   (out_swap_total),
    .out_end_of_run   (out_end_of_run),
    .out_dropped_keys (out_dropped_keys)
  );

  // The 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The predictor's own copy of the block's state: the keys of the set
  // being loaded, how many of them fit, and whether any fell off the end.
  logic [KEY_W-1:0] loaded_keys [CAPACITY];
  int               loaded_total;
  logic             keys_lost;

  // The results of the most recent final key, and the sorted keys still
  // to come out of the block, oldest first.
  sorted_result_t   fresh_run[$];
  sorted_result_t   awaited_keys[$];

  sorted_result_t   head_result;
  int               error_count;
  int               cycle_count;
  int               random_sent;

  // The directed table. It covers a lone smallest key and a lone largest
  // key, both extremes in one set, a reversed set, a set of equal keys,
  // single set bits at both ends of the key, alternating bit patterns,
  // and a plain one-key set.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'd0,     1'b1, 1'b1, '{16'd0,     11'd0, 1'b1, 1'b0}},
    '{16'd65535, 1'b1, 1'b1, '{16'd65535, 11'd0, 1'b1, 1'b0}},
    '{16'd65535, 1'b0, 1'b0, '0},
    '{16'd0,     1'b1, 1'b0, '0},
    '{16'd500,   1'b0, 1'b0, '0},
    '{16'd400,   1'b0, 1'b0, '0},
    '{16'd300,   1'b0, 1'b0, '0},
    '{16'd200,   1'b0, 1'b0, '0},
    '{16'd100,   1'b1, 1'b0, '0},
    '{16'd7,     1'b0, 1'b0, '0},
    '{16'd7,     1'b0, 1'b0, '0},
    '{16'd7,     1'b1, 1'b0, '0},
    '{16'h8000,  1'b0, 1'b0, '0},
    '{16'h00FF,  1'b0, 1'b0, '0},
    '{16'hFF00,  1'b0, 1'b0, '0},
    '{16'h0001,  1'b1, 1'b0, '0},
    '{16'hAAAA,  1'b0, 1'b0, '0},
    '{16'h5555,  1'b0, 1'b0, '0},
    '{16'h5555,  1'b1, 1'b0, '0},
    '{16'd12345, 1'b1, 1'b1, '{16'd12345, 11'd0, 1'b1, 1'b0}}
  };

  // Takes one accepted key into the predictor. A key that finds the store
  // full is dropped, and the set is marked. On the final key the stored
  // keys are bubble-sorted in place, and every exchange of two neighbors
  // is counted, with the count saturating. The sorted run is left in
  // fresh_run, and the state clears for the next set.
  function automatic void absorb_key(input logic [KEY_W-1:0] key, input logic last);
    logic [KEY_W-1:0]  held;
    logic [SWAP_W-1:0] swaps;
    sorted_result_t    r;
    fresh_run.delete();
    if (loaded_total < CAPACITY) begin
      loaded_keys[loaded_total] = key;
      loaded_total++;
    end else begin
      keys_lost = 1'b1;
    end
    if (last) begin
      swaps = '0;
      for (int pass = 1; pass < loaded_total; pass++) begin
        for (int pos = 0; pos + pass < loaded_total; pos++) begin
          if (loaded_keys[pos] > loaded_keys[pos+1]) begin
            held               = loaded_keys[pos];
            loaded_keys[pos]   = loaded_keys[pos+1];
            loaded_keys[pos+1] = held;
            if (swaps != SWAP_SAT) begin
              swaps++;
            end
          end
        end
      end
      // Only the last key of the run carries the swap count and the end mark.
      for (int k = 0; k < loaded_total; k++) begin
        r.key        = loaded_keys[k];
        r.end_of_run = (k == loaded_total - 1);
        r.swaps      = r.end_of_run ? swaps : '0;
        r.dropped    = keys_lost;
        fresh_run    = {fresh_run, r};
      end
      loaded_total = 0;
      keys_lost    = 1'b0;
    end
  endfunction

  // Presents one item after a random pause and holds it until the block
  // takes it. The item is taken at an edge where start is high and busy
  // is low. Sampling busy right at the edge sees the value from before
  // that edge. With no pause, start simply stays high, and only the
  // fields change.
  task automatic drive_item(input logic [KEY_W-1:0] key, input logic last,
                            input logic typed, input sorted_result_t typed_result);
    int pause;
    pause = $urandom_range(0, 3);
    if (pause != 0) begin
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    start        <= 1'b1;
    in_key_in    <= key;
    in_final_key <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_key(key, last);
    if (typed) begin
      awaited_keys = {awaited_keys, typed_result};
    end else begin
      awaited_keys = {awaited_keys, fresh_run};
    end
  endtask

  // Draws one key of a random set. The kind of set decides its character:
  // keys anywhere in the range, a narrow range that gives many equal keys,
  // only the two extremes, or a rising sequence that needs few swaps.
  function automatic logic [KEY_W-1:0] draw_key(input int kind, input int idx);
    case (kind)
      0:       return KEY_W'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return KEY_W'(idx * 900 + $urandom_range(0, 899));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Sends one random set. Most sets are short, so the sort stays quick.
  // Some are of middling length. Now and then a set runs past the store's
  // capacity, so that the overflow path is exercised.
  task automatic send_random_set();
    int pick;
    int set_len;
    int kind;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      set_len = $urandom_range(1, 8);
    end else if (pick < 92) begin
      set_len = $urandom_range(9, 32);
    end else begin
      set_len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
    end
    kind = $urandom_range(0, 5);
    for (int i = 0; i < set_len; i++) begin
      drive_item(draw_key(kind, i), (i == set_len - 1), 1'b0, '0);
      random_sent++;
    end
  endtask

  // Every result on the output is checked against the oldest sorted key
  // still awaited. The output is sampled at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_keys.size() == 0) begin
        $error("unexpected result: sorted_key %0d arrived with nothing awaited",
               out_sorted_key);
        error_count++;
      end else begin
        head_result = awaited_keys.pop_front();
        if (out_sorted_key !== head_result.key) begin
          $error("sorted_key: expected %0d, actual %0d", head_result.key, out_sorted_key);
          error_count++;
        end
        if (out_swap_total !== head_result.swaps) begin
          $error("swap_total: expected %0d, actual %0d", head_result.swaps, out_swap_total);
          error_count++;
        end
        if (out_end_of_run !== head_result.end_of_run) begin
          $error("end_of_run: expected %0d, actual %0d", head_result.end_of_run,
                 out_end_of_run);
          error_count++;
        end
        if (out_dropped_keys !== head_result.dropped) begin
          $error("dropped_keys: expected %0d, actual %0d", head_result.dropped,
                 out_dropped_keys);
          error_count++;
        end
      end
    end
  end

  // This watchdog ends the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    random_sent  = 0;
    loaded_total = 0;
    keys_lost    = 1'b0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_key_in    <= '0;
    in_final_key <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].key, directed_rows[i].final_key,
                 directed_rows[i].typed, directed_rows[i].result);
    end

    // This set fills the store with keys in falling order, which forces the
    // largest possible number of swaps. Two further keys are dropped. The
    // final key is one of them, and it must still start the sort.
    for (int k = 0; k < CAPACITY + 2; k++) begin
      drive_item(KEY_W'(64000 - k * 1000), (k == CAPACITY + 1), 1'b0, '0);
    end

    while (random_sent < RANDOM_ITEMS) begin
      send_random_set();
    end
    start <= 1'b0;

    // Wait until every awaited key has come out. Then watch a little
    // longer for any result that should not be there.
    while (awaited_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
